>>> hw/rtl/sha_pkg.sv
// package: types, constants and round functions of the sha-256 byte stream hasher
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam int CountW = 61;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;

    // controller to datapath commands
    typedef struct packed {
        logic load_byte;
        logic write_pad;
        logic len_field;
        logic init_rounds;
        logic do_round;
        logic fold;
        logic reset_chain;
        logic shift_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } t_status;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_core.sv
// top level of the sha-256 byte stream hasher
// usage:
//   input channel (i_valid / o_ready, i_item) takes one item per message byte;
//   byte_present marks a real byte, end_of_message closes the message.
//   output channel (o_valid / i_ready, o_item) gives four 64-bit digest words,
//   most significant first, word_index 0..3, last_word on the fourth.
// flow:
//   a byte that does not fill the block leaves the input ready; the 64th byte
//   of a block then holds the input off through round setup, rounds and fold
//   in the single shared round unit, so no new byte is taken until the fold.
//   the end item pads the rest of the block (a whole second block when the
//   length field does not fit) and is followed by one or two compressions,
//   then the four words, one per cycle when taken.
// reset: the chain value returns to the initial hash, byte count to zero.
// stall: while the receiver holds ready low the current word stays on the
//   port and no new item is taken until all four words have left.
module sha256_byte_stream_hasher_core
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_cmd        cmd;
    t_status     status;
    logic [7:0]  pbyte;
    logic [1:0]  idx;
    logic [63:0] dw;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .o_word_index(idx), .i_status(status), .o_cmd(cmd), .o_byte(pbyte)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(pbyte),
        .o_status(status), .o_digest_word(dw)
    );

    // result item
    assign o_item.digest_word = dw;
    assign o_item.word_index = idx;
    assign o_item.last_word = (idx == 2'd3);

endmodule

>>> hw/rtl/sha_datapath.sv
// datapath: block shift register and message schedule, round registers, chain value
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    output t_status     o_status,
    output logic [63:0] o_digest_word
);

    logic [CountW-1:0] r_count;
    logic [5:0]        r_pad_pos;
    t_word             r_w [16];
    t_word             r_v [8];
    t_word             r_h [8];
    logic [5:0]        r_round;
    logic [63:0]       bits;
    logic [7:0]        shift_byte;
    t_word             big1, big0, ch, maj, t1, s0, s1, w_new;

    assign bits = {r_count, 3'b000};
    assign o_status.fill = r_pad_pos;
    assign o_status.round_last = (r_round == 6'd63);
    assign o_digest_word = {r_h[0], r_h[1]};

    // byte entering the block: message byte, pad byte or length field byte
    always_comb begin
        shift_byte = i_byte;
        if (i_cmd.write_pad && i_cmd.len_field && r_pad_pos >= LenPos)
            shift_byte = bits[8*(7 - r_pad_pos[2:0]) +: 8];
    end

    // byte count and fill pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pad_pos <= '0;
        end else if (i_cmd.reset_chain) begin
            r_count <= '0;
            r_pad_pos <= '0;
        end else if (i_cmd.load_byte) begin
            r_count <= r_count + 1'b1;
            r_pad_pos <= r_pad_pos + 1'b1;
        end else if (i_cmd.write_pad) begin
            r_pad_pos <= r_pad_pos + 1'b1;
        end
    end

    // schedule and round logic
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + big1 + ch + round_k(r_round) + r_w[0];
        big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    // block bytes shift in big-endian, then the same registers run the schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte || i_cmd.write_pad) begin
            for (int t = 0; t < 15; t++)
                r_w[t] <= {r_w[t][23:0], r_w[t+1][31:24]};
            r_w[15] <= {r_w[15][23:0], shift_byte};
        end else if (i_cmd.init_rounds) begin
            for (int i = 0; i < 8; i++)
                r_v[i] <= r_h[i];
            r_round <= '0;
        end else if (i_cmd.do_round) begin
            for (int t = 0; t < 15; t++)
                r_w[t] <= r_w[t+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + big0 + maj;
            r_round <= r_round + 1'b1;
        end
    end

    // chain value: fold, shift out, reinitialize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_chain) begin
            for (int i = 0; i < 8; i++)
                r_h[i] <= init_h(3'(i));
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++)
                r_h[i] <= r_h[i] + r_v[i];
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 6; i++)
                r_h[i] <= r_h[i+2];
            r_h[6] <= r_h[0];
            r_h[7] <= r_h[1];
        end
    end

endmodule

>>> hw/rtl/sha_ctrl.sv
// controller: item handshake, padding sequence, rounds and digest output
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output logic [1:0] o_word_index,
    input  t_status   i_status,
    output t_cmd      o_cmd,
    output logic [7:0] o_byte
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_INIT  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic       r_final, n_final;
    logic       r_first_pad, n_first_pad;
    logic       r_in_pad, n_in_pad;
    logic [1:0] r_idx, n_idx;
    logic       acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_index = r_idx;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_first_pad = r_first_pad;
        n_in_pad = r_in_pad;
        n_idx = r_idx;
        o_cmd = '0;
        o_byte = i_item.data_byte;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load_byte = i_item.byte_present;
                    n_first_pad = 1'b1;
                    n_in_pad = i_item.end_of_message;
                    if (i_item.byte_present && i_status.fill == 6'd63)
                        n_state = S_INIT;
                    else if (i_item.end_of_message)
                        n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.write_pad = 1'b1;
                o_cmd.len_field = r_final;
                o_byte = r_first_pad ? PadByte : 8'h00;
                n_first_pad = 1'b0;
                // the length field fits only when the pad byte lands before it
                if (r_first_pad)
                    n_final = (i_status.fill < LenPos);
                if (i_status.fill == 6'd63)
                    n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_rounds = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (i_status.round_last)
                    n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!r_in_pad)
                    n_state = S_IDLE;
                else if (r_final)
                    n_state = S_OUT;
                else begin
                    // the next block starts empty and always carries the length
                    n_final = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        o_cmd.shift_out = 1'b0;
                        o_cmd.reset_chain = 1'b1;
                        n_state = S_IDLE;
                        n_final = 1'b0;
                        n_in_pad = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
            r_first_pad <= 1'b0;
            r_in_pad <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_first_pad <= n_first_pad;
            r_in_pad <= n_in_pad;
            r_idx <= n_idx;
        end
    end

endmodule

>>> verif/tb_sha256_byte_stream_hasher_core.sv
// testbench for the sha-256 byte stream hasher: directed table plus random messages
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher_core
    import sha_pkg::*;
();

    localparam int StallLimit = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    sha256_byte_stream_hasher_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hash state of the predictor
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_count;

    t_out_item digest_words_due [$];
    int        n_errors;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;
    bit        sending_done;

    // round constants, written out here so the predictor stands on its own
    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] HInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_chain[i] = HInit[i];
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        msg_count = '0;
    endtask

    // one 64-round compression of msg_block into hash_chain
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
    endtask

    // predict the digest words caused by one accepted item
    task automatic predict_hash_item(input t_in_item it);
        int          fill;
        logic [63:0] bits;
        t_out_item   o;
        if (it.byte_present) begin
            msg_block[msg_count[5:0]] = it.data_byte;
            msg_count = msg_count + 1'b1;
            if (msg_count[5:0] == 6'd0) compress();
        end
        if (!it.end_of_message) return;
        fill = msg_count[5:0];
        msg_block[fill] = PadByte;
        fill++;
        if (fill > 56) begin
            for (; fill < 64; fill++) msg_block[fill] = 8'h00;
            compress();
            fill = 0;
        end
        for (; fill < 56; fill++) msg_block[fill] = 8'h00;
        bits = {msg_count, 3'b000};
        for (int k = 0; k < 8; k++) msg_block[56+k] = bits[8*(7-k) +: 8];
        compress();
        for (int k = 0; k < 4; k++) begin
            o.digest_word = {hash_chain[2*k], hash_chain[2*k+1]};
            o.word_index  = k[1:0];
            o.last_word   = (k == 3);
            digest_words_due.push_back(o);
        end
        clear_hash();
    endtask

    // drive one item and wait for its acceptance; valid drops only while idling
    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_item  <= '{data_byte: b, byte_present: p, end_of_message: e};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_hash_item('{data_byte: b, byte_present: p, end_of_message: e});
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), 1'b1,
                      (i == len - 1) && ($urandom_range(1) == 0));
        if (len == 0 || i_item.end_of_message == 1'b0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // stop offering items and wait for all expected words
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (digest_words_due.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random stall plus an optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // output check
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_words_due.size() == 0) begin
                $error("digest word with none expected: %h", o_item.digest_word);
                n_errors++;
            end else begin
                exp_w = digest_words_due.pop_front();
                if (o_item.digest_word !== exp_w.digest_word) begin
                    $error("digest_word exp %h got %h", exp_w.digest_word, o_item.digest_word);
                    n_errors++;
                end
                if (o_item.word_index !== exp_w.word_index) begin
                    $error("word_index exp %0d got %0d", exp_w.word_index, o_item.word_index);
                    n_errors++;
                end
                if (o_item.last_word !== exp_w.last_word) begin
                    $error("last_word exp %0d got %0d", exp_w.last_word, o_item.last_word);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("[sha256_byte_stream_hasher_core] ERROR");
            $finish;
        end
    end

    // directed rows: data byte, byte present, end of message
    localparam int NDir = 14;
    localparam logic [9:0] DirTab [NDir] = '{
        {8'h00, 1'b0, 1'b1},             // empty message
        {8'h61, 1'b1, 1'b0}, {8'h62, 1'b1, 1'b0}, {8'h63, 1'b1, 1'b1},  // "abc"
        {8'hff, 1'b1, 1'b1},             // byte with end
        {8'h00, 1'b1, 1'b0}, {8'h55, 1'b0, 1'b0}, {8'haa, 1'b0, 1'b0},  // a byte, then no-byte filler
        {8'h00, 1'b0, 1'b1},             // end without byte
        {8'haa, 1'b1, 1'b0}, {8'h55, 1'b1, 1'b0}, {8'h80, 1'b1, 1'b0},
        {8'h01, 1'b1, 1'b0}, {8'hfe, 1'b0, 1'b1}};

    // digests of the empty message and "abc"
    localparam logic [255:0] EmptyDigest =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] AbcDigest =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // stimulus
    initial begin
        logic [255:0] exp_d;
        int           n_lens [2];
        n_errors = 0; idle_cycles = 0; hold_off = 0; sending_done = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_valid = 1'b0; i_item = '0; i_ready = 1'b0; i_rst_n = 1'b0;
        clear_hash();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; check the known digests against the predictor too
        for (int r = 0; r < NDir; r++) begin
            send_item(DirTab[r][9:2], DirTab[r][1], DirTab[r][0]);
            if (r == 0 || r == 3) begin
                exp_d = (r == 0) ? EmptyDigest : AbcDigest;
                for (int k = 0; k < 4; k++)
                    if (digest_words_due[digest_words_due.size()-4+k].digest_word
                        !== exp_d[255-64*k -: 64]) begin
                        $error("digest_word exp %h got %h", exp_d[255-64*k -: 64],
                               digest_words_due[digest_words_due.size()-4+k].digest_word);
                        n_errors++;
                    end
            end
        end
        drain();

        // padding boundaries: length field just fits, second block needed
        n_lens = '{55, 56};
        for (int i = 0; i < 2; i++) send_message(n_lens[i]);

        // random phases with differing idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 60) : 0;
            recv_stall_pct = (ph == 2) ? 60 : ((ph == 3) ? 32 : 0);
            for (int m = 0; m < 2; m++)
                send_message($urandom_range(0, 5));
            // noise: an item with no byte and no end
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        end

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 1;
        fork
            begin
                send_message(3);
                send_message(5);
            end
            begin
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
        join
        drain();
        sending_done = 1;
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && digest_words_due.size() == 0)
            $display("[sha256_byte_stream_hasher_core] OK");
        else
            $display("[sha256_byte_stream_hasher_core] ERROR");
        $finish;
    end

endmodule
